### rtl/lmrc_pkg.sv
// Shared constants, codes and types for the lift motor ramp controller.
package lmrc_pkg;

   // Field widths.
   localparam int unsigned CMD_W     = 2;
   localparam int unsigned STATUS_W  = 2;
   localparam int unsigned DUTY_W    = 10;
   localparam int unsigned TIME_W    = 32;
   localparam int unsigned TIMEOUT_W = 31;

   // Command codes.
   localparam logic [CMD_W-1:0] CMD_STOP = 2'd0;
   localparam logic [CMD_W-1:0] CMD_UP   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DOWN = 2'd2;

   // Status codes.
   localparam logic [STATUS_W-1:0] STATUS_RUN   = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_ERROR = 2'd2;

   // Ramp constants.
   localparam logic [DUTY_W-1:0] FULL_SPEED = 10'd1022;
   localparam logic [DUTY_W-1:0] RAMP_STEP  = 10'd2;
   localparam logic [DUTY_W-1:0] BRAKE_STEP = 10'd600;

   // Timeout register value after reset.
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 31'd10000;

   // Effect of one direction's poll on the shared driver outputs.
   typedef struct packed {
      logic                duty_we;
      logic [DUTY_W-1:0]   duty;
      logic                other_clr;
      logic                en_set;
      logic                en_clr;
      logic [STATUS_W-1:0] status;
   } dir_act_type;

endpackage

### rtl/lmrc_ifs.sv
// Handshake interfaces for the poll, result and configuration channels.
interface lmrc_req_if;
   logic                           valid;
   logic                           ready;
   logic [lmrc_pkg::CMD_W-1:0]     command;
   logic                           limit_up;
   logic                           limit_down;
   logic [lmrc_pkg::TIME_W-1:0]    time_ms;

   modport source (output valid, command, limit_up, limit_down, time_ms, input ready);
   modport sink   (input valid, command, limit_up, limit_down, time_ms, output ready);
endinterface

interface lmrc_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [lmrc_pkg::STATUS_W-1:0]  status;
   logic                           motor_enable;
   logic [lmrc_pkg::DUTY_W-1:0]    duty_up;
   logic [lmrc_pkg::DUTY_W-1:0]    duty_down;

   modport source (output valid, status, motor_enable, duty_up, duty_down, input ready);
   modport sink   (input valid, status, motor_enable, duty_up, duty_down, output ready);
endinterface

interface lmrc_csr_if;
   logic                           valid;
   logic                           ready;
   logic [lmrc_pkg::TIMEOUT_W-1:0] timeout_ms;

   modport source (output valid, timeout_ms, input ready);
   modport sink   (input valid, timeout_ms, output ready);
endinterface

### rtl/lift_motor_ramp_controller_top.sv
// Top level of the lift motor ramp controller: input stage, shared outputs, result stage.
//
//  Channel | Dir | Handshake     | Payload
//  req     | in  | valid / ready | command, limit_up, limit_down, time_ms
//  rsp     | out | valid / ready | status, motor_enable, duty_up, duty_down
//  csr     | in  | valid / ready | timeout_ms
//
// One item per cycle while the result is not stalled; an accepted item passes the input
// register, then the single update pass into the result register, which offers it.
// Reset clears every phase, speed, start time, duty and the enable level, and
// loads the timeout with 10000. A stalled result holds the result register and
// the input register; req.ready falls only while both are full. csr is always ready.
module lift_motor_ramp_controller_top (
   input  logic              clock,
   input  logic              reset,
   lmrc_req_if.sink          req,
   lmrc_rsp_if.source        rsp,
   lmrc_csr_if.sink          csr
);

   // Input register.
   logic                              in_valid_ff;
   logic [lmrc_pkg::CMD_W-1:0]        in_cmd_ff;
   logic                              in_sens_up_ff;
   logic                              in_sens_down_ff;
   logic [lmrc_pkg::TIME_W-1:0]       in_time_ff;

   // Configuration and shared driver state.
   logic [lmrc_pkg::TIMEOUT_W-1:0]    timeout_ff;
   logic                              enable_ff, enable_in;
   logic [lmrc_pkg::DUTY_W-1:0]       duty_up_ff, duty_up_in;
   logic [lmrc_pkg::DUTY_W-1:0]       duty_down_ff, duty_down_in;
   logic [lmrc_pkg::STATUS_W-1:0]     status_in;

   // Result register.
   logic                              rsp_valid_ff;
   logic [lmrc_pkg::STATUS_W-1:0]     rsp_status_ff;
   logic                              rsp_enable_ff;
   logic [lmrc_pkg::DUTY_W-1:0]       rsp_duty_up_ff;
   logic [lmrc_pkg::DUTY_W-1:0]       rsp_duty_down_ff;

   logic                              advance;
   logic                              accept;
   logic                              is_stop, is_up, is_down;
   lmrc_pkg::dir_act_type             up_act, down_act;

   // The update pass runs when the result register is free or being emptied.
   assign advance   = in_valid_ff && (!rsp_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;
   assign accept    = req.valid && req.ready;
   assign csr.ready = 1'b1;

   assign is_stop = in_cmd_ff == lmrc_pkg::CMD_STOP;
   assign is_up   = in_cmd_ff == lmrc_pkg::CMD_UP;
   assign is_down = in_cmd_ff == lmrc_pkg::CMD_DOWN;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (accept) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_cmd_ff       <= req.command;
         in_sens_up_ff   <= req.limit_up;
         in_sens_down_ff <= req.limit_down;
         in_time_ff      <= req.time_ms;
      end
   end

   // Timeout register.
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= lmrc_pkg::TIMEOUT_RESET;
      end else if (csr.valid) begin
         timeout_ff <= csr.timeout_ms;
      end
   end

   // One direction unit for each travel direction.
   lmrc_dir u_dir_up (
      .clock   (clock),
      .reset   (reset),
      .step    (advance && is_up),
      .stop    (advance && is_stop),
      .hit     (in_sens_up_ff),
      .now     (in_time_ff),
      .timeout (timeout_ff),
      .act     (up_act)
   );

   lmrc_dir u_dir_down (
      .clock   (clock),
      .reset   (reset),
      .step    (advance && is_down),
      .stop    (advance && is_stop),
      .hit     (in_sens_down_ff),
      .now     (in_time_ff),
      .timeout (timeout_ff),
      .act     (down_act)
   );

   // Apply a stop, or the selected direction's effect, to the shared driver outputs.
   always_comb begin
      enable_in    = enable_ff;
      duty_up_in   = duty_up_ff;
      duty_down_in = duty_down_ff;
      status_in    = lmrc_pkg::STATUS_RUN;
      if (is_stop) begin
         enable_in    = 1'b0;
         duty_up_in   = '0;
         duty_down_in = '0;
      end else if (is_up) begin
         status_in = up_act.status;
         if (up_act.duty_we) begin
            duty_up_in = up_act.duty;
         end
         if (up_act.other_clr) begin
            duty_down_in = '0;
         end
         if (up_act.en_set) begin
            enable_in = 1'b1;
         end
         if (up_act.en_clr) begin
            enable_in = 1'b0;
         end
      end else if (is_down) begin
         status_in = down_act.status;
         if (down_act.duty_we) begin
            duty_down_in = down_act.duty;
         end
         if (down_act.other_clr) begin
            duty_up_in = '0;
         end
         if (down_act.en_set) begin
            enable_in = 1'b1;
         end
         if (down_act.en_clr) begin
            enable_in = 1'b0;
         end
      end
   end

   // Shared driver state.
   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff    <= 1'b0;
         duty_up_ff   <= '0;
         duty_down_ff <= '0;
      end else if (advance) begin
         enable_ff    <= enable_in;
         duty_up_ff   <= duty_up_in;
         duty_down_ff <= duty_down_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_status_ff    <= status_in;
         rsp_enable_ff    <= enable_in;
         rsp_duty_up_ff   <= duty_up_in;
         rsp_duty_down_ff <= duty_down_in;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.motor_enable = rsp_enable_ff;
   assign rsp.duty_up      = rsp_duty_up_ff;
   assign rsp.duty_down    = rsp_duty_down_ff;

`ifndef NO_ASSERTIONS
   // The poll channel stalls only behind a full, stalled result register.
   a_ready_only_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req.ready |-> (rsp_valid_ff && !rsp.ready))
      else $error("req.ready low without a stalled result");

   // A stop item leaves the driver disabled with both duties at zero.
   a_stop_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && is_stop) |=> (!enable_ff && duty_up_ff == '0 && duty_down_ff == '0))
      else $error("stop item did not clear the driver outputs");

   // A result carries the shared driver state that its item left behind.
   a_rsp_matches_state: assert property (@(posedge clock) disable iff (reset)
      advance |=> (rsp_enable_ff == enable_ff && rsp_duty_up_ff == duty_up_ff
                   && rsp_duty_down_ff == duty_down_ff))
      else $error("result register disagrees with driver state");
`endif

endmodule

### rtl/lmrc_dir.sv
// State and poll logic of one travel direction (phase, speed, start time).
module lmrc_dir (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             step,
   input  logic                             stop,
   input  logic                             hit,
   input  logic [lmrc_pkg::TIME_W-1:0]      now,
   input  logic [lmrc_pkg::TIMEOUT_W-1:0]   timeout,
   output lmrc_pkg::dir_act_type            act
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_RAMP,
      PH_WAIT,
      PH_BRAKE,
      PH_DONE
   } phase_type;

   phase_type                      phase_ff, phase_in;
   logic [lmrc_pkg::DUTY_W-1:0]    speed_ff, speed_in;
   logic [lmrc_pkg::TIME_W-1:0]    start_ff, start_in;
   logic [lmrc_pkg::TIME_W-1:0]    elapsed;
   logic                           timed_out;

   // Elapsed time wraps at the counter width.
   assign elapsed   = now - start_ff;
   assign timed_out = elapsed > {1'b0, timeout};

   // Next state and driver effect of a poll in the present phase.
   always_comb begin
      phase_in = phase_ff;
      speed_in = speed_ff;
      start_in = start_ff;
      act      = '0;
      act.status = lmrc_pkg::STATUS_RUN;
      unique case (phase_ff)
         PH_IDLE: begin
            start_in      = now;
            speed_in      = '0;
            phase_in      = PH_RAMP;
            act.en_set    = 1'b1;
            act.other_clr = 1'b1;
            act.duty_we   = 1'b1;
            act.duty      = '0;
         end
         PH_RAMP: begin
            if (hit) begin
               phase_in = PH_BRAKE;
            end
            // Reaching full speed takes precedence over a sensor hit.
            if (speed_ff >= lmrc_pkg::FULL_SPEED) begin
               phase_in = PH_WAIT;
               speed_in = lmrc_pkg::FULL_SPEED;
            end else begin
               speed_in    = speed_ff + lmrc_pkg::RAMP_STEP;
               act.duty_we = 1'b1;
               act.duty    = speed_ff + lmrc_pkg::RAMP_STEP;
            end
         end
         PH_WAIT: begin
            if (timed_out) begin
               speed_in    = '0;
               act.duty_we = 1'b1;
               act.duty    = '0;
               act.status  = lmrc_pkg::STATUS_ERROR;
            end else if (hit) begin
               speed_in = '0;
               phase_in = PH_BRAKE;
            end
         end
         PH_BRAKE: begin
            act.duty_we = 1'b1;
            if (speed_ff <= lmrc_pkg::BRAKE_STEP) begin
               speed_in   = '0;
               phase_in   = PH_DONE;
               act.en_clr = 1'b1;
               act.duty   = '0;
            end else begin
               speed_in = speed_ff - lmrc_pkg::BRAKE_STEP;
               act.duty = speed_ff - lmrc_pkg::BRAKE_STEP;
            end
         end
         PH_DONE: begin
            act.status = lmrc_pkg::STATUS_DONE;
         end
         default: begin
            act.status = lmrc_pkg::STATUS_RUN;
         end
      endcase
   end

   // Direction state; a stop clears phase and speed but keeps the start time.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         speed_ff <= '0;
         start_ff <= '0;
      end else if (stop) begin
         phase_ff <= PH_IDLE;
         speed_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         speed_ff <= speed_in;
         start_ff <= start_in;
      end
   end

endmodule
